[design/modular_exponentiation_core_macros.svh]
// Assertion macros for the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mexp_pkg.sv]
package mexp_pkg;

  localparam int OPERAND_WIDTH_DEF = 63;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

[design/mexp_mulmod.sv]
// Shift-add modular multiplier: res = (a * b) mod m, one bit of b per cycle,
// MSB first. Needs a < m, or a = m = 1.
module mexp_mulmod #(
  parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic [OPERAND_WIDTH-1:0] res,
  output mexp_pkg::mul_stat_t      stat
);

  localparam int CW = $clog2(OPERAND_WIDTH);

  logic [OPERAND_WIDTH-1:0] acc;
  logic [OPERAND_WIDTH-1:0] a_r;
  logic [OPERAND_WIDTH-1:0] b_r;
  logic [OPERAND_WIDTH-1:0] m_r;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic                     done;

  logic [OPERAND_WIDTH:0]   dbl;
  logic [OPERAND_WIDTH:0]   red1;
  logic [OPERAND_WIDTH:0]   sum;
  logic [OPERAND_WIDTH:0]   red2;
  logic [OPERAND_WIDTH-1:0] acc_next;

  always_comb begin
    dbl  = {acc, 1'b0};
    red1 = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum  = {1'b0, red1[OPERAND_WIDTH-1:0]} + {1'b0, a_r};
    red2 = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    acc_next = b_r[OPERAND_WIDTH-1] ? red2[OPERAND_WIDTH-1:0]
                                    : red1[OPERAND_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(OPERAND_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      m_r <= m;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= {b_r[OPERAND_WIDTH-2:0], 1'b0};
    end
  end

  assign res       = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[design/modular_exponentiation_core.sv]
// Modular exponentiation core: power_result = base^exponent mod m.
// Input: drive base, exponent, modulus and use_default_modulus with start
// high; the word is taken at the edge where start is high and busy is low.
// use_default_modulus selects m = 2^OPERAND_WIDTH - 1 instead of modulus.
// Output: power_result is valid for the single cycle in which done is high;
// the receiver must take it then, there is no way to hold it.
// A zero exponent or a zero modulus answers in the cycle after the word is
// taken. Otherwise the shared shift-add multiplier runs one modular product
// after another: one reduction of base, one square per exponent bit below
// the top set bit, and one multiply per set bit.
// Throughput: one word at a time; busy is high for the whole computation,
// but stays low on the zero-exponent and zero-modulus path.
// A new word may be started in the cycle done is high.
// Reset: rst (synchronous) returns the sequencer to idle and drops busy and
// done; a computation in flight is lost.
module modular_exponentiation_core #(
  parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] base,
  input  logic [OPERAND_WIDTH-1:0] exponent,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  input  logic                     use_default_modulus,
  output logic [OPERAND_WIDTH-1:0] power_result,
  output logic                     done
);

  `include "modular_exponentiation_core_macros.svh"

  // Sequencer codes: RED reduces base mod m, MUL folds sq into acc,
  // SQR squares sq.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SQR  = 2'd3;

  localparam logic [OPERAND_WIDTH-1:0] ONE = OPERAND_WIDTH'(1);

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [OPERAND_WIDTH-1:0] exp_r;
  logic [OPERAND_WIDTH-1:0] exp_next;
  logic [OPERAND_WIDTH-1:0] m_r;
  logic [OPERAND_WIDTH-1:0] sq;
  logic [OPERAND_WIDTH-1:0] sq_next;
  logic [OPERAND_WIDTH-1:0] acc;
  logic [OPERAND_WIDTH-1:0] acc_next;

  logic [OPERAND_WIDTH-1:0] m_sel;
  logic                     accept;
  logic                     exp_bit;
  logic                     finish;

  logic                     unit_go;
  logic [OPERAND_WIDTH-1:0] unit_a;
  logic [OPERAND_WIDTH-1:0] unit_b;
  logic [OPERAND_WIDTH-1:0] unit_m;
  logic [OPERAND_WIDTH-1:0] unit_res;
  mexp_pkg::mul_stat_t      unit_stat;

  assign m_sel  = use_default_modulus ? {OPERAND_WIDTH{1'b1}} : modulus;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign unit_m = (state == S_IDLE) ? m_sel : m_r;

  // Next operation of the shared multiplier, launched on an accepted word or chosen as the last one ends.
  always_comb begin
    state_next = state;
    exp_next   = exp_r;
    sq_next    = sq;
    acc_next   = acc;
    finish     = 1'b0;
    unit_go    = 1'b0;
    unit_a     = unit_res;
    unit_b     = unit_res;
    exp_bit    = (state == S_SQR) ? exp_r[1] : exp_r[0];
    case (state)
      S_IDLE: begin
        if (accept && (exponent != '0) && (m_sel != '0)) begin
          unit_go    = 1'b1;
          unit_a     = ONE;
          unit_b     = base;
          state_next = S_RED;
        end
      end
      S_RED, S_SQR: begin
        if (unit_stat.done) begin
          sq_next = unit_res;
          if (state == S_SQR) begin
            exp_next = exp_r >> 1;
          end
          unit_go = 1'b1;
          if (exp_bit) begin
            unit_a     = acc;
            state_next = S_MUL;
          end else begin
            state_next = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (unit_stat.done) begin
          acc_next = unit_res;
          if (exp_r[OPERAND_WIDTH-1:1] == '0) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            unit_go    = 1'b1;
            unit_a     = sq;
            unit_b     = sq;
            state_next = S_SQR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  mexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (unit_go),
    .a    (unit_a),
    .b    (unit_b),
    .m    (unit_m),
    .res  (unit_res),
    .stat (unit_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish || (accept && ((exponent == '0) || (m_sel == '0)));
    end
  end

  // Datapath; a modulus of one leaves acc at zero from the start.
  always_ff @(posedge clk) begin
    if (accept) begin
      exp_r <= exponent;
      m_r   <= m_sel;
      acc   <= (m_sel == ONE) ? '0 : ONE;
      if (exponent == '0) begin
        power_result <= ONE;
      end else if (m_sel == '0) begin
        power_result <= '0;
      end
    end else begin
      exp_r <= exp_next;
      acc   <= acc_next;
    end
    sq <= sq_next;
    if (finish) begin
      power_result <= unit_res;
    end
  end

  `MEXP_ASSERT_NEXT(a_zero_exp, start && !busy && (exponent == '0), done && (power_result == ONE), "zero exponent must answer 1 next cycle")
  `MEXP_ASSERT_NOW(a_unit_free, unit_go, !unit_stat.busy, "multiplier launched while busy")
  `MEXP_ASSERT_NOW(a_exp_live, busy, exp_r != '0, "exponent exhausted while running")
  `MEXP_ASSERT_NOW(a_unit_idle, !busy, !unit_stat.busy, "multiplier running while sequencer idle")

endmodule
